// ===== hw/rtl/cbrd_pkg.sv =====
// Shared types and constants for the chained run-length decoder.
// No dependencies; every other file of the block imports this package.
package cbrd_pkg;

    // Code bytes of the compressed stream.
    localparam logic [7:0] RUN_CODE       = 8'hC0;
    localparam logic [7:0] ESC_CODE       = 8'hE0;
    localparam logic [7:0] WAVE_CODE      = 8'hF0;
    localparam logic [7:0] INSTR_CODE     = 8'hF1;
    localparam logic [7:0] FIRST_UNKNOWN  = 8'hF2;
    localparam logic [7:0] END_CODE       = 8'hFF;

    // Decoder phases.
    localparam logic [2:0] PH_CODE     = 3'd0;
    localparam logic [2:0] PH_RUN_MARK = 3'd1;
    localparam logic [2:0] PH_RUN_VAL  = 3'd2;
    localparam logic [2:0] PH_ESCAPE   = 3'd3;
    localparam logic [2:0] PH_DEFAULT  = 3'd4;

    // Result kinds.
    localparam logic [1:0] K_DATA = 2'd0;
    localparam logic [1:0] K_JUMP = 2'd1;
    localparam logic [1:0] K_DONE = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    // Pattern selectors for data runs.
    localparam logic [1:0] PAT_BYTE  = 2'd0;
    localparam logic [1:0] PAT_WAVE  = 2'd1;
    localparam logic [1:0] PAT_INSTR = 2'd2;

    // Error codes.
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_TOO_LONG   = 4'd1;
    localparam logic [3:0] ERR_RUN_CUT    = 4'd2;
    localparam logic [3:0] ERR_NO_COUNT   = 4'd3;
    localparam logic [3:0] ERR_ESC_CUT    = 4'd4;
    localparam logic [3:0] ERR_DEF_CUT    = 4'd5;
    localparam logic [3:0] ERR_UNKNOWN    = 4'd6;
    localparam logic [3:0] ERR_BAD_JUMP   = 4'd7;
    localparam logic [3:0] ERR_PAST_END   = 4'd8;
    localparam logic [3:0] ERR_RAN_PAST   = 4'd9;
    localparam logic [3:0] ERR_WRONG_SIZE = 4'd10;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SEQ_MODE  = 2'd0;
    localparam logic [1:0] CFG_LIMIT     = 2'd1;
    localparam logic [1:0] CFG_START     = 2'd2;
    localparam logic [1:0] CFG_EXP_LEN   = 2'd3;

    // Result queue depth; one byte may produce two results.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;

    typedef struct packed {
        logic        seq_mode;
        logic [7:0]  block_limit;
        logic [7:0]  start_block;
        logic [15:0] expected_len;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [7:0] count;
        logic [1:0] pattern;
        logic [7:0] next_block;
        logic [3:0] error_code;
        logic       last;
    } result_t;

endpackage

// ===== hw/rtl/cbrd_cfg_regs.sv =====
// Configuration registers of the chained run-length decoder.
// Depends on cbrd_pkg for the register indexes and the cfg_t struct.
module cbrd_cfg_regs (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [1:0]       wr_index,
    input  logic [15:0]      wr_data,
    output cbrd_pkg::cfg_t   cfg
);
    import cbrd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seq_mode     <= 1'b0;
            cfg_reg.block_limit  <= 8'd191;
            cfg_reg.start_block  <= 8'd0;
            cfg_reg.expected_len <= 16'd32768;
        end else if (wr_en) begin
            case (wr_index)
                CFG_SEQ_MODE: cfg_reg.seq_mode     <= wr_data[0];
                CFG_LIMIT:    cfg_reg.block_limit  <= wr_data[7:0];
                CFG_START:    cfg_reg.start_block  <= wr_data[7:0];
                CFG_EXP_LEN:  cfg_reg.expected_len <= wr_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/cbrd_decoder.sv =====
// Code-phase machine and stream counters of the chained run-length decoder.
// Depends on cbrd_pkg; produces up to two result descriptors per accepted byte.
module cbrd_decoder #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic              op,
    input  logic [7:0]        byte_in,
    input  logic              flag,
    input  cbrd_pkg::cfg_t    cfg,
    output cbrd_pkg::result_t res0,
    output cbrd_pkg::result_t res1,
    output logic [1:0]        res_num
);
    import cbrd_pkg::*;

    localparam logic [8:0] MaxBlk = 9'(MAX_BLOCKS);

    logic [2:0]  phase_reg,   phase_next;
    logic [7:0]  held_reg,    held_next;
    logic [16:0] total_reg,   total_next;
    logic [8:0]  visited_reg, visited_next;
    logic [7:0]  block_reg,   block_next;
    logic        stopped_reg, stopped_next;

    logic        do_run, do_fail, do_jump, do_done;
    logic [7:0]  run_val, run_cnt;
    logic [1:0]  run_pat;
    logic [7:0]  fail_blk;
    logic [3:0]  fail_code;
    logic [8:0]  jump_blk;
    logic [8:0]  visited_inc;
    logic [16:0] run_len;
    result_t     fail_res;

    function automatic logic past_end(input logic [8:0] b, input cfg_t c);
        logic lim;
        lim = (b > {1'b0, c.block_limit}) || (b >= MaxBlk);
        return lim || (!c.seq_mode && (b == 9'd0));
    endfunction

    always_comb begin
        phase_next   = phase_reg;
        held_next    = held_reg;
        visited_next = visited_reg;
        block_next   = block_reg;
        stopped_next = stopped_reg;
        do_run    = 1'b0;
        do_fail   = 1'b0;
        do_jump   = 1'b0;
        do_done   = 1'b0;
        run_val   = 8'd0;
        run_cnt   = 8'd1;
        run_pat   = PAT_BYTE;
        fail_blk  = block_reg;
        fail_code = ERR_NONE;
        jump_blk  = cfg.seq_mode ? ({1'b0, block_reg} + 9'd1) : {1'b0, byte_in};
        visited_inc = visited_reg + 9'd1;

        if (fire && !op) begin
            phase_next   = PH_CODE;
            held_next    = 8'd0;
            visited_next = 9'd0;
            block_next   = cfg.start_block;
            stopped_next = 1'b0;
            if (past_end({1'b0, cfg.start_block}, cfg)) begin
                do_fail      = 1'b1;
                fail_blk     = cfg.start_block;
                fail_code    = ERR_PAST_END;
                stopped_next = 1'b1;
            end
        end else if (fire && !stopped_reg) begin
            case (phase_reg)
                PH_CODE: begin
                    if (total_reg > {1'b0, cfg.expected_len}) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_TOO_LONG;
                    end else if (byte_in == RUN_CODE) begin
                        if (flag) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_RUN_CUT;
                        end else begin
                            phase_next = PH_RUN_MARK;
                        end
                    end else if (byte_in == ESC_CODE) begin
                        if (flag) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_ESC_CUT;
                        end else begin
                            phase_next = PH_ESCAPE;
                        end
                    end else begin
                        do_run  = 1'b1;
                        run_val = byte_in;
                    end
                end
                PH_RUN_MARK: begin
                    if (byte_in == RUN_CODE) begin
                        do_run  = 1'b1;
                        run_val = RUN_CODE;
                    end else if (flag) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_NO_COUNT;
                    end else begin
                        held_next  = byte_in;
                        phase_next = PH_RUN_VAL;
                    end
                end
                PH_RUN_VAL: begin
                    do_run  = 1'b1;
                    run_val = held_reg;
                    run_cnt = byte_in;
                end
                PH_ESCAPE: begin
                    phase_next = PH_CODE;
                    if (byte_in == ESC_CODE) begin
                        do_run  = 1'b1;
                        run_val = ESC_CODE;
                    end else if (byte_in == WAVE_CODE || byte_in == INSTR_CODE) begin
                        if (flag) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_DEF_CUT;
                        end else begin
                            held_next  = byte_in;
                            phase_next = PH_DEFAULT;
                        end
                    end else if (byte_in == END_CODE) begin
                        if (total_reg == {1'b0, cfg.expected_len}) begin
                            do_done      = 1'b1;
                            stopped_next = 1'b1;
                        end else begin
                            do_fail   = 1'b1;
                            fail_code = ERR_WRONG_SIZE;
                        end
                    end else if (byte_in >= FIRST_UNKNOWN) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_UNKNOWN;
                    end else begin
                        fail_blk = jump_blk[7:0];
                        if ((jump_blk > {1'b0, cfg.block_limit}) || (jump_blk >= MaxBlk)) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_BAD_JUMP;
                        end else begin
                            visited_next = visited_inc;
                            if (visited_inc > ({1'b0, cfg.block_limit} + 9'd1)) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_BAD_JUMP;
                            end else if (past_end(jump_blk, cfg)) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_PAST_END;
                            end else begin
                                do_jump    = 1'b1;
                                block_next = jump_blk[7:0];
                            end
                        end
                    end
                end
                PH_DEFAULT: begin
                    do_run  = 1'b1;
                    run_cnt = byte_in;
                    run_pat = (held_reg == WAVE_CODE) ? PAT_WAVE : PAT_INSTR;
                end
                default: begin
                    phase_next = PH_CODE;
                end
            endcase

            // A data code that ends on the block's last byte overran its block.
            if (do_run) begin
                phase_next = PH_CODE;
                if (flag) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_RAN_PAST;
                end
            end
            if (do_fail) begin
                stopped_next = 1'b1;
            end
        end
    end

    assign run_len    = (run_pat != PAT_BYTE) ? {5'd0, run_cnt, 4'd0} : {9'd0, run_cnt};
    assign total_next = (fire && !op) ? 17'd0 : (do_run ? total_reg + run_len : total_reg);

    always_comb begin
        fail_res            = '0;
        fail_res.kind       = K_ERR;
        fail_res.next_block = fail_blk;
        fail_res.error_code = fail_code;
        fail_res.last       = 1'b1;

        res0    = '0;
        res1    = fail_res;
        res_num = 2'd0;
        if (do_run) begin
            res0.kind    = K_DATA;
            res0.value   = (run_pat == PAT_BYTE) ? run_val : 8'd0;
            res0.count   = run_cnt;
            res0.pattern = run_pat;
            res0.last    = !do_fail;
            res_num      = do_fail ? 2'd2 : 2'd1;
        end else if (do_jump) begin
            res0.kind       = K_JUMP;
            res0.next_block = jump_blk[7:0];
            res0.last       = 1'b1;
            res_num         = 2'd1;
        end else if (do_done) begin
            res0.kind = K_DONE;
            res0.last = 1'b1;
            res_num   = 2'd1;
        end else if (do_fail) begin
            res0    = fail_res;
            res_num = 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_CODE;
            held_reg    <= 8'd0;
            total_reg   <= 17'd0;
            visited_reg <= 9'd0;
            block_reg   <= 8'd0;
            stopped_reg <= 1'b0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            total_reg   <= total_next;
            visited_reg <= visited_next;
            block_reg   <= block_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// ===== hw/rtl/cbrd_result_fifo.sv =====
// Result queue of the chained run-length decoder: takes zero, one or two
// descriptors a cycle and presents one at a time. Depends on cbrd_pkg.
module cbrd_result_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             push_num,
    input  cbrd_pkg::result_t      push0,
    input  cbrd_pkg::result_t      push1,
    input  logic                   pop,
    output cbrd_pkg::result_t      head,
    output logic [cbrd_pkg::RQ_AW:0] count
);
    import cbrd_pkg::*;

    result_t           mem_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [RQ_AW:0]    count_reg, count_next;
    logic              do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign count_next = count_reg + {1'b0, push_num} - {{RQ_AW{1'b0}}, do_pop};

    always_ff @(posedge aclk) begin
        if (push_num != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_num == 2'd2) begin
            mem_reg[wr_ptr_reg + RQ_AW'(1)] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_num[RQ_AW-1:0];
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + RQ_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (RQ_AW+1)'(RQ_DEPTH))
        else $error("result queue count beyond depth");

    a_pair_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_num == 2'd2) |-> (count_reg <= (RQ_AW+1)'(RQ_DEPTH - 2)))
        else $error("two results pushed without two free slots");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && push_num == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not reduce the queue count");

endmodule

// ===== hw/rtl/block_chained_rle_decoder.sv =====
// Chained run-length decoder: compressed bytes in, run descriptors out.
// Depends on cbrd_pkg, cbrd_cfg_regs, cbrd_decoder and cbrd_result_fifo.
//
// One compressed byte is accepted per clock cycle while s_ready is high. Each
// byte is decoded in the cycle it is accepted and its descriptors (at most
// two: a data run followed by a ran-past-block error) go into a four-entry
// result queue; s_ready is high while that queue has two free slots. Results
// leave at one per cycle while m_ready is high, so the two descriptors of one
// byte come out in turn. The configuration port is always ready and must be
// written only while the decoder is idle. There is no clearing pass after reset.
module block_chained_rle_decoder #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_byte_in,
    input  logic        s_last_in_block,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_value,
    output logic [7:0]  m_count,
    output logic [1:0]  m_pattern,
    output logic [7:0]  m_next_block,
    output logic [3:0]  m_error_code,
    output logic        m_last
);
    import cbrd_pkg::*;

    cfg_t            cfg;
    result_t         res0, res1, head;
    logic [1:0]      res_num;
    logic [RQ_AW:0]  q_count;
    logic            fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = (q_count <= (RQ_AW+1)'(RQ_DEPTH - 2));
    assign fire      = s_valid && s_ready;

    cbrd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cbrd_decoder #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .op      (s_op),
        .byte_in (s_byte_in),
        .flag    (s_last_in_block),
        .cfg     (cfg),
        .res0    (res0),
        .res1    (res1),
        .res_num (res_num)
    );

    cbrd_result_fifo u_rq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_num (res_num),
        .push0    (res0),
        .push1    (res1),
        .pop      (m_ready),
        .head     (head),
        .count    (q_count)
    );

    assign m_valid      = (q_count != '0);
    assign m_kind       = head.kind;
    assign m_value      = head.value;
    assign m_count      = head.count;
    assign m_pattern    = head.pattern;
    assign m_next_block = head.next_block;
    assign m_error_code = head.error_code;
    assign m_last       = head.last;

endmodule

// ===== tb/sv/rle_scoreboard_pkg.sv =====
// Scoreboard for the chained run-length decoder: a cycle-free predictor of the
// decoder plus the queue of descriptors it expects. Depends on cbrd_pkg.
`timescale 1ns / 1ps
package rle_scoreboard_pkg;
    import cbrd_pkg::*;

    localparam int TB_MAX_BLOCKS = 256;

    class rle_scoreboard;
        // Configuration as last written through the register port.
        bit        seq_mode;
        bit [7:0]  block_limit;
        bit [7:0]  start_block;
        bit [15:0] expected_len;

        // Decoder state.
        bit [2:0]  code_phase;
        bit [7:0]  held_value;
        bit [16:0] decoded_total;
        bit [8:0]  visited_blocks;
        bit [7:0]  current_block;
        bit        stopped;

        result_t   pending[$];
        int        effective_items;
        int        errors;

        function new();
            seq_mode = 1'b0;
            block_limit = 8'd191;
            start_block = 8'd0;
            expected_len = 16'd32768;
            code_phase = PH_CODE;
            held_value = 8'd0;
            decoded_total = 17'd0;
            visited_blocks = 9'd0;
            current_block = 8'd0;
            stopped = 1'b0;
            effective_items = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_SEQ_MODE: seq_mode = data[0];
                CFG_LIMIT:    block_limit = data[7:0];
                CFG_START:    start_block = data[7:0];
                CFG_EXP_LEN:  expected_len = data;
                default: ;
            endcase
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] value, logic [7:0] count,
                                  logic [1:0] pattern, logic [7:0] blk, logic [3:0] err);
            result_t r;
            r.kind = kind;
            r.value = value;
            r.count = count;
            r.pattern = pattern;
            r.next_block = blk;
            r.error_code = err;
            r.last = 1'b0;
            pending = {pending, r};
        endfunction

        function void raise_error(logic [7:0] blk, logic [3:0] err);
            push_result(K_ERR, 8'd0, 8'd0, PAT_BYTE, blk, err);
            stopped = 1'b1;
        endfunction

        function bit past_end(int blk);
            return blk > int'(block_limit) || blk >= TB_MAX_BLOCKS || (!seq_mode && blk == 0);
        endfunction

        function void emit_run(logic [7:0] value, logic [7:0] count, logic [1:0] pattern,
                               logic flagged);
            push_result(K_DATA, value, count, pattern, 8'd0, ERR_NONE);
            if (pattern != PAT_BYTE)
                decoded_total = decoded_total + {5'd0, count, 4'd0};
            else
                decoded_total = decoded_total + {9'd0, count};
            code_phase = PH_CODE;
            // A data code may not finish on the last byte of a block.
            if (flagged) raise_error(current_block, ERR_RAN_PAST);
        endfunction

        function void follow_jump(logic [7:0] b);
            int nb;
            logic [7:0] nb_low;
            nb = seq_mode ? int'(current_block) + 1 : int'(b);
            nb_low = nb[7:0];
            if (nb > int'(block_limit) || nb >= TB_MAX_BLOCKS) begin
                raise_error(nb_low, ERR_BAD_JUMP);
            end else begin
                visited_blocks = visited_blocks + 9'd1;
                if (int'(visited_blocks) > int'(block_limit) + 1)
                    raise_error(nb_low, ERR_BAD_JUMP);
                else if (past_end(nb))
                    raise_error(nb_low, ERR_PAST_END);
                else begin
                    current_block = nb_low;
                    push_result(K_JUMP, 8'd0, 8'd0, PAT_BYTE, nb_low, ERR_NONE);
                end
            end
        endfunction

        // Called for every accepted input transaction.
        function void note_input(logic op, logic [7:0] b, logic fl);
            int first;
            result_t r;
            first = pending.size();
            if (op == 1'b0) begin
                effective_items++;
                code_phase = PH_CODE;
                held_value = 8'd0;
                decoded_total = 17'd0;
                visited_blocks = 9'd0;
                current_block = start_block;
                stopped = 1'b0;
                if (past_end(int'(start_block))) raise_error(start_block, ERR_PAST_END);
            end else if (!stopped) begin
                effective_items++;
                case (code_phase)
                    PH_CODE: begin
                        if (decoded_total > {1'b0, expected_len})
                            raise_error(current_block, ERR_TOO_LONG);
                        else if (b == RUN_CODE) begin
                            if (fl) raise_error(current_block, ERR_RUN_CUT);
                            else code_phase = PH_RUN_MARK;
                        end else if (b == ESC_CODE) begin
                            if (fl) raise_error(current_block, ERR_ESC_CUT);
                            else code_phase = PH_ESCAPE;
                        end else
                            emit_run(b, 8'd1, PAT_BYTE, fl);
                    end
                    PH_RUN_MARK: begin
                        if (b == RUN_CODE) emit_run(RUN_CODE, 8'd1, PAT_BYTE, fl);
                        else if (fl) raise_error(current_block, ERR_NO_COUNT);
                        else begin
                            held_value = b;
                            code_phase = PH_RUN_VAL;
                        end
                    end
                    PH_RUN_VAL: emit_run(held_value, b, PAT_BYTE, fl);
                    PH_ESCAPE: begin
                        code_phase = PH_CODE;
                        if (b == ESC_CODE)
                            emit_run(ESC_CODE, 8'd1, PAT_BYTE, fl);
                        else if (b == WAVE_CODE || b == INSTR_CODE) begin
                            if (fl) raise_error(current_block, ERR_DEF_CUT);
                            else begin
                                held_value = b;
                                code_phase = PH_DEFAULT;
                            end
                        end else if (b == END_CODE) begin
                            if (decoded_total == {1'b0, expected_len}) begin
                                push_result(K_DONE, 8'd0, 8'd0, PAT_BYTE, 8'd0, ERR_NONE);
                                stopped = 1'b1;
                            end else
                                raise_error(current_block, ERR_WRONG_SIZE);
                        end else if (b >= FIRST_UNKNOWN)
                            raise_error(current_block, ERR_UNKNOWN);
                        else
                            follow_jump(b);
                    end
                    PH_DEFAULT: emit_run(8'd0, b,
                                         (held_value == WAVE_CODE) ? PAT_WAVE : PAT_INSTR, fl);
                    default: code_phase = PH_CODE;
                endcase
            end
            if (pending.size() > first) begin
                r = pending[pending.size() - 1];
                r.last = 1'b1;
                pending[pending.size() - 1] = r;
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        // Called for every result transaction leaving the decoder.
        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                errors++;
                $error("descriptor with nothing expected: kind %0d error_code %0d",
                       got.kind, got.error_code);
            end else begin
                want = pending.pop_front();
                compare_field("kind", 16'(want.kind), 16'(got.kind));
                compare_field("value", 16'(want.value), 16'(got.value));
                compare_field("count", 16'(want.count), 16'(got.count));
                compare_field("pattern", 16'(want.pattern), 16'(got.pattern));
                compare_field("next_block", 16'(want.next_block), 16'(got.next_block));
                compare_field("error_code", 16'(want.error_code), 16'(got.error_code));
                compare_field("last", 16'(want.last), 16'(got.last));
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top level of the decoder testbench: clock, reset, stimulus and response check.
// Depends on cbrd_pkg, rle_scoreboard_pkg and block_chained_rle_decoder.
`timescale 1ns / 1ps
module tb_top;
    import cbrd_pkg::*;
    import rle_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DECODE_ITEMS = 1650;
    localparam int NUM_PHASES = 10;

    typedef enum int {RX_STREAM, RX_COIN, RX_PATTERN, RX_SLOW} rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [7:0]  s_byte_in;
    logic        s_last_in_block;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [7:0]  m_value;
    logic [7:0]  m_count;
    logic [1:0]  m_pattern;
    logic [7:0]  m_next_block;
    logic [3:0]  m_error_code;
    logic        m_last;

    rle_scoreboard sb;
    int          cycle_count = 0;
    int          burst_left = 0;

    // Copy of the current settings, used to shape well-formed streams.
    bit          cur_seq;
    logic [7:0]  cur_limit;
    logic [15:0] cur_len;

    block_chained_rle_decoder #(.MAX_BLOCKS(TB_MAX_BLOCKS)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_byte_in(s_byte_in),
        .s_last_in_block(s_last_in_block),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_value(m_value),
        .m_count(m_count),
        .m_pattern(m_pattern),
        .m_next_block(m_next_block),
        .m_error_code(m_error_code),
        .m_last(m_last)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Inputs, configuration writes and results are all observed here, in one
    // process, so an input is always noted before its results can be checked.
    always @(posedge aclk) begin
        result_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_input(s_op, s_byte_in, s_last_in_block);
            if (m_valid && m_ready) begin
                got.kind = m_kind;
                got.value = m_value;
                got.count = m_count;
                got.pattern = m_pattern;
                got.next_block = m_next_block;
                got.error_code = m_error_code;
                got.last = m_last;
                sb.check_result(got);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side back-pressure: switches between several stall behaviors.
    initial begin
        rx_mode_t   mode;
        int         mode_left;
        logic [7:0] stall_mask;
        mode = RX_STREAM;
        mode_left = 0;
        stall_mask = 8'hFF;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (mode_left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
                stall_mask = 8'($urandom) | 8'h01;
            end
            mode_left--;
            case (mode)
                RX_STREAM: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_PATTERN: begin
                    m_ready <= stall_mask[0];
                    stall_mask = {stall_mask[0], stall_mask[7:1]};
                end
                RX_SLOW:   m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= 1'b1;
            endcase
        end
    end

    // Sends one transaction; the sender works in bursts separated by gaps.
    task automatic send_item(input logic op, input logic [7:0] b, input logic fl);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_op <= op;
        s_byte_in <= b;
        s_last_in_block <= fl;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops the sender and waits until every expected descriptor has left.
    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg_port(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_config(input bit seq, input logic [7:0] lim, input logic [7:0] start,
                                input logic [15:0] len);
        cur_seq = seq;
        cur_limit = lim;
        cur_len = len;
        write_reg_port(CFG_SEQ_MODE, {15'd0, seq});
        write_reg_port(CFG_LIMIT, {8'd0, lim});
        write_reg_port(CFG_START, {8'd0, start});
        write_reg_port(CFG_EXP_LEN, len);
        cfg_valid <= 1'b0;
    endtask

    // A stream of valid codes that adds up to the expected length and then ends.
    // With overshoot set, counts are not clamped, so the length usually comes
    // out wrong or too long.
    task automatic run_clean_stream(input bit overshoot);
        int         remaining;
        int         cap;
        int         guard;
        int         n;
        logic [7:0] v;
        send_item(1'b0, 8'($urandom), 1'($urandom));
        remaining = int'(cur_len);
        guard = 0;
        while (remaining > 0 && guard < 120) begin
            guard++;
            cap = (overshoot || remaining > 255) ? 255 : remaining;
            case ($urandom_range(0, 9))
                3: begin
                    send_item(1'b1, RUN_CODE, 1'b0);
                    send_item(1'b1, RUN_CODE, 1'b0);
                    remaining -= 1;
                end
                4: begin
                    send_item(1'b1, ESC_CODE, 1'b0);
                    send_item(1'b1, ESC_CODE, 1'b0);
                    remaining -= 1;
                end
                5, 6: begin
                    v = 8'($urandom);
                    if (v == RUN_CODE) v = 8'h3F;
                    n = $urandom_range(0, cap);
                    send_item(1'b1, RUN_CODE, 1'b0);
                    send_item(1'b1, v, 1'b0);
                    send_item(1'b1, n[7:0], 1'b0);
                    remaining -= n;
                end
                7: begin
                    if (overshoot || remaining >= 16) begin
                        n = $urandom_range(0, overshoot ? 255 : (cap > 15 ? cap / 16 : 1));
                        if (!overshoot && n * 16 > remaining) n = remaining / 16;
                        send_item(1'b1, ESC_CODE, 1'b0);
                        send_item(1'b1, $urandom_range(0, 1) ? WAVE_CODE : INSTR_CODE, 1'b0);
                        send_item(1'b1, n[7:0], 1'b0);
                        remaining -= n * 16;
                    end else begin
                        send_item(1'b1, 8'h01, 1'b0);
                        remaining -= 1;
                    end
                end
                8: begin
                    // Block jumps; the end-of-block flag may sit on the target byte.
                    if (cur_seq)
                        v = 8'($urandom_range(0, 8'hDF));
                    else if (cur_limit != 8'd0)
                        v = 8'($urandom_range(1, (cur_limit > 8'hDF) ? 8'hDF : cur_limit));
                    else
                        v = 8'h00;
                    if (cur_seq || cur_limit != 8'd0) begin
                        send_item(1'b1, ESC_CODE, 1'b0);
                        send_item(1'b1, v, ($urandom_range(0, 3) == 0));
                    end
                end
                default: begin
                    v = 8'($urandom);
                    if (v == RUN_CODE || v == ESC_CODE) v = v + 8'd1;
                    send_item(1'b1, v, 1'b0);
                    remaining -= 1;
                end
            endcase
        end
        send_item(1'b1, ESC_CODE, 1'b0);
        send_item(1'b1, END_CODE, ($urandom_range(0, 1) == 1));
    endtask

    // Random bytes biased toward code bytes, with stray flags and restarts.
    task automatic run_noise_stream();
        int         len;
        logic [7:0] v;
        send_item(1'b0, 8'($urandom), 1'($urandom));
        len = $urandom_range(1, 24);
        repeat (len) begin
            case ($urandom_range(0, 11))
                0: v = RUN_CODE;
                1: v = ESC_CODE;
                2: v = WAVE_CODE;
                3: v = INSTR_CODE;
                4: v = END_CODE;
                5: v = 8'($urandom_range(FIRST_UNKNOWN, 8'hFE));
                6: v = 8'($urandom_range(0, 8'hEF));
                default: v = 8'($urandom);
            endcase
            send_item(($urandom_range(0, 19) != 0), v, ($urandom_range(0, 4) == 0));
        end
    endtask

    initial begin
        bit         seq;
        logic [7:0] lim;
        logic [7:0] start;
        logic [15:0] len;
        int         target;
        sb = new();
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SEQ_MODE;
        cfg_data <= 16'd0;
        s_valid <= 1'b0;
        s_op <= 1'b0;
        s_byte_in <= 8'd0;
        s_last_in_block <= 1'b0;
        cur_seq = 1'b0;
        cur_limit = 8'd191;
        cur_len = 16'd32768;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed codes under the reset settings. The first bytes come before
        // any stream start and decode as block 0.
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'hFF, 1'b0);
        send_item(1'b1, RUN_CODE, 1'b0);
        send_item(1'b1, RUN_CODE, 1'b0);
        send_item(1'b1, RUN_CODE, 1'b0);
        send_item(1'b1, 8'h55, 1'b0);
        send_item(1'b1, 8'hFF, 1'b0);
        send_item(1'b1, ESC_CODE, 1'b0);
        send_item(1'b1, ESC_CODE, 1'b0);
        send_item(1'b1, ESC_CODE, 1'b0);
        send_item(1'b1, WAVE_CODE, 1'b0);
        send_item(1'b1, 8'h00, 1'b0);
        // Default run that finishes on the block's last byte.
        send_item(1'b1, ESC_CODE, 1'b0);
        send_item(1'b1, INSTR_CODE, 1'b0);
        send_item(1'b1, 8'h03, 1'b1);
        // Start block 0 is past the end when jumps name their block.
        send_item(1'b0, 8'hFF, 1'b1);
        quiesce();

        apply_config(1'b0, 8'd255, 8'd5, 16'd20);
        send_item(1'b0, 8'h00, 1'b0);
        send_item(1'b1, ESC_CODE, 1'b0);
        send_item(1'b1, 8'h07, 1'b1);
        send_item(1'b1, RUN_CODE, 1'b0);
        send_item(1'b1, 8'hAA, 1'b1);
        send_item(1'b0, 8'h00, 1'b0);
        send_item(1'b1, RUN_CODE, 1'b1);
        quiesce();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin seq = 1'b1; lim = 8'd0;   start = 8'd0;   len = 16'd1;     end
                1: begin seq = 1'b0; lim = 8'd255; start = 8'd255; len = 16'd300;   end
                2: begin seq = 1'b1; lim = 8'd255; start = 8'd250; len = 16'd200;   end
                3: begin seq = 1'b0; lim = 8'd191; start = 8'd10;  len = 16'd65535; end
                4: begin seq = 1'b0; lim = 8'd2;   start = 8'd1;   len = 16'd64;    end
                default: begin
                    seq = 1'($urandom_range(0, 1));
                    lim = 8'($urandom);
                    if (lim == 8'd0) seq = 1'b1;
                    start = 8'($urandom_range(seq ? 0 : 1, lim));
                    len = 16'($urandom_range(1, 600));
                end
            endcase
            apply_config(seq, lim, start, len);
            target = sb.effective_items + DECODE_ITEMS / NUM_PHASES;
            while (sb.effective_items < target) begin
                if ($urandom_range(0, 4) == 0)
                    run_noise_stream();
                else
                    run_clean_stream($urandom_range(0, 7) == 0);
            end
            quiesce();
        end

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
